// ===== rtl/sps_pkg.sv =====
// Shared types and constants for the stepper position sequencer.
// Depends on nothing; imported by the sequencer top level.
`default_nettype none

package sps_pkg;

    localparam int QUEUE_DEPTH   = 32;
    localparam int POSITION_BITS = 16;

    localparam int CMD_W   = 3;
    localparam int ARG_W   = 16;
    localparam int MODE_W  = 2;
    localparam int POS_W   = 16;
    localparam int PEND_W  = 6;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_GOTO  = 3'd1,
        CMD_WAIT  = 3'd2,
        CMD_SPEED = 3'd3,
        CMD_CAL   = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ARG_W-1:0] argument;
        logic             detector;
    } sps_req_t;

    typedef struct packed {
        logic              step_left;
        logic              step_right;
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  position;
        logic [PEND_W-1:0] pending;
        logic              dropped;
    } sps_rsp_t;

    typedef struct packed {
        logic [CMD_W-1:0] code;
        logic [ARG_W-1:0] arg;
    } fifo_entry_t;

endpackage

`default_nettype wire

// ===== rtl/sps_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the command queue of the sequencer.
`default_nettype none

module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/stepper_position_sequencer_top.sv =====
// Top level of the stepper position sequencer: tick timing, motion control and command queue.
// Depends on sps_pkg for types and constants and on sps_ram for the queue storage.
`default_nettype none

// The block takes one request per clock cycle while req_stall is low, ticks and commands alike,
// and returns one registered result per request. Commands are queued in a 32-entry RAM
// with a registered read; the RAM is read every cycle at the next head address, so the head
// command is ready when a tick pops it, and a command written to an empty queue is forwarded.
// Results pass through a two-entry output buffer, so req_stall rises only when both entries
// hold results that have not been taken.
module stepper_position_sequencer_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output      logic              req_stall,
    input  wire sps_pkg::sps_req_t req,
    output      logic              rsp_valid,
    input  wire logic              rsp_stall,
    output      sps_pkg::sps_rsp_t rsp
);

    import sps_pkg::*;

    typedef enum logic [MODE_W-1:0] {
        MODE_CAL  = 2'd0,
        MODE_IDLE = 2'd1,
        MODE_MOVE = 2'd2
    } mode_t;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] tgt_reg, tgt_next;
    logic [ARG_W-1:0]         delay_reg, delay_next;
    logic [ARG_W-1:0]         cd_reg, cd_next;
    logic [ARG_W-1:0]         cd_dec;
    logic [PTR_W-1:0]         rd_reg, rd_next;
    logic [PTR_W-1:0]         wr_reg, wr_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     bypass_reg;
    fifo_entry_t              bypass_data_reg;
    fifo_entry_t              ram_rdata;
    fifo_entry_t              head;
    fifo_entry_t              push_data;
    logic                     push;
    logic                     req_acc;
    logic                     left, right, dropped;
    sps_rsp_t                 result;
    sps_rsp_t                 rsp_reg;
    sps_rsp_t                 skid_reg;
    logic                     rsp_valid_reg;
    logic                     skid_valid_reg;
    logic [CNT_W:0]           chk_sum;
    logic [CNT_W:0]           chk_wr;

    assign req_stall = skid_valid_reg;
    assign req_acc   = req_valid && !skid_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign head      = bypass_reg ? bypass_data_reg : ram_rdata;
    assign push_data = '{code: req.command, arg: req.argument};

    sps_ram #(
        .WIDTH ($bits(fifo_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (push),
        .waddr (wr_reg),
        .wdata (push_data),
        .raddr (rd_next),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        tgt_next   = tgt_reg;
        delay_next = delay_reg;
        cd_next    = cd_reg;
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        count_next = count_reg;
        push       = 1'b0;
        left       = 1'b0;
        right      = 1'b0;
        dropped    = 1'b0;
        cd_dec     = (cd_reg != '0) ? cd_reg - 1'b1 : '0;
        if (req_acc)
        begin
            if (req.command == CMD_TICK)
            begin
                cd_next = cd_dec;
                if (cd_dec == '0)
                begin
                    case (mode_reg)
                        MODE_IDLE:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_next    = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                             '0 : rd_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                                case (head.code)
                                    CMD_GOTO:
                                    begin
                                        tgt_next  = POSITION_BITS'(head.arg);
                                        mode_next = MODE_MOVE;
                                    end
                                    CMD_WAIT, CMD_SPEED:
                                    begin
                                        delay_next = head.arg;
                                    end
                                    CMD_CAL:
                                    begin
                                        mode_next = MODE_CAL;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                        MODE_MOVE:
                        begin
                            if (pos_reg > tgt_reg)
                            begin
                                left     = 1'b1;
                                pos_next = pos_reg - 1'b1;
                            end
                            else if (pos_reg < tgt_reg)
                            begin
                                right    = 1'b1;
                                pos_next = pos_reg + 1'b1;
                            end
                            else
                            begin
                                mode_next = MODE_IDLE;
                            end
                        end
                        default:
                        begin
                            if (req.detector)
                            begin
                                right = 1'b1;
                            end
                            else
                            begin
                                mode_next = MODE_IDLE;
                                pos_next  = '0;
                                tgt_next  = '0;
                            end
                        end
                    endcase
                    cd_next = (delay_next == '0) ? ARG_W'(1) : delay_next;
                end
            end
            else if (req.command <= CMD_CAL)
            begin
                if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    push       = 1'b1;
                    wr_next    = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result            = '0;
        result.step_left  = left;
        result.step_right = right;
        result.mode       = mode_next;
        result.position   = POS_W'(pos_next);
        result.pending    = PEND_W'(count_next);
        result.dropped    = dropped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_CAL;
            pos_reg         <= '0;
            tgt_reg         <= '0;
            delay_reg       <= ARG_W'(1);
            cd_reg          <= '0;
            rd_reg          <= '0;
            wr_reg          <= '0;
            count_reg       <= '0;
            bypass_reg      <= 1'b0;
            bypass_data_reg <= '0;
            rsp_reg         <= '0;
            skid_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            pos_reg         <= pos_next;
            tgt_reg         <= tgt_next;
            delay_reg       <= delay_next;
            cd_reg          <= cd_next;
            rd_reg          <= rd_next;
            wr_reg          <= wr_next;
            count_reg       <= count_next;
            bypass_reg      <= push && (wr_reg == rd_next);
            bypass_data_reg <= push_data;
            if (!rsp_valid_reg || !rsp_stall)
            begin
                if (skid_valid_reg)
                begin
                    rsp_reg        <= skid_reg;
                    rsp_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    rsp_reg       <= result;
                    rsp_valid_reg <= req_acc;
                end
            end
            else if (req_acc)
            begin
                skid_reg       <= result;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign chk_sum = (CNT_W + 1)'(rd_reg) + (CNT_W + 1)'(count_reg);
    assign chk_wr  = (chk_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) ?
                     chk_sum - (CNT_W + 1)'(QUEUE_DEPTH) : chk_sum;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
    else $error("Queue count exceeds the queue depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        chk_wr == (CNT_W + 1)'(wr_reg))
    else $error("Queue pointers disagree with the queue count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> rsp_valid_reg)
    else $error("Skid entry holds a result while the output entry is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.step_left && rsp_reg.step_right))
    else $error("Result steps in both directions at once.");

endmodule

`default_nettype wire

// ===== verif/tb_stepper_position_sequencer_top.sv =====
// Self-checking testbench for stepper_position_sequencer_top: directed table, then random phases.
// Depends on sps_pkg and the sequencer RTL; predicts each result from its own copy of the state.
`timescale 1ns / 1ps

module tb_stepper_position_sequencer_top;
    import sps_pkg::*;

    localparam logic [MODE_W-1:0] MODE_CAL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MOVE = 2'd2;

    localparam int FIRST_UNUSED_CMD = int'(CMD_CAL) + 1;
    localparam int LAST_CMD_CODE    = (1 << CMD_W) - 1;
    localparam int DIRECTED_ROWS    = 25;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int PHASES           = 4;

    localparam sps_rsp_t NO_RESULT = '0;

    typedef struct packed {
        sps_req_t stim;
        logic     typed;
        sps_rsp_t want;
    } directed_row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    sps_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    sps_rsp_t rsp;

    int send_gap_pct       = 0;
    int hold_pct           = 0;
    int mismatch_count     = 0;
    int accepted_requests  = 0;

    sps_rsp_t expected_results[$];

    logic [MODE_W-1:0]        seq_mode      = MODE_CAL;
    logic [POSITION_BITS-1:0] seq_position  = '0;
    logic [POSITION_BITS-1:0] seq_target    = '0;
    logic [ARG_W-1:0]         seq_delay     = 16'd1;
    logic [ARG_W-1:0]         seq_countdown = '0;
    fifo_entry_t              seq_backlog[$];

    directed_row_t plan [DIRECTED_ROWS];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stepper_position_sequencer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    function automatic sps_rsp_t advance_sequencer(input sps_req_t r);
        sps_rsp_t    o;
        fifo_entry_t head;
        o = '0;
        if (r.command == CMD_TICK)
        begin
            if (seq_countdown != '0)
                seq_countdown--;
            if (seq_countdown == '0)
            begin
                case (seq_mode)
                    MODE_IDLE:
                    begin
                        if (seq_backlog.size() != 0)
                        begin
                            head = seq_backlog.pop_front();
                            case (head.code)
                                CMD_GOTO:
                                begin
                                    seq_target = head.arg[POSITION_BITS-1:0];
                                    seq_mode   = MODE_MOVE;
                                end
                                CMD_WAIT, CMD_SPEED: seq_delay = head.arg;
                                CMD_CAL:             seq_mode  = MODE_CAL;
                                default:             ;
                            endcase
                        end
                    end
                    MODE_MOVE:
                    begin
                        if (seq_position > seq_target)
                        begin
                            o.step_left  = 1'b1;
                            seq_position = seq_position - 1'b1;
                        end
                        else if (seq_position < seq_target)
                        begin
                            o.step_right = 1'b1;
                            seq_position = seq_position + 1'b1;
                        end
                        else
                            seq_mode = MODE_IDLE;
                    end
                    default:
                    begin
                        if (r.detector)
                            o.step_right = 1'b1;
                        else
                        begin
                            seq_mode     = MODE_IDLE;
                            seq_position = '0;
                            seq_target   = '0;
                        end
                    end
                endcase
                seq_countdown = (seq_delay == '0) ? 16'd1 : seq_delay;
            end
        end
        else if (r.command <= CMD_CAL)
        begin
            if (seq_backlog.size() >= QUEUE_DEPTH)
                o.dropped = 1'b1;
            else
            begin
                head.code = r.command;
                head.arg  = r.argument;
                seq_backlog.push_back(head);
            end
        end
        o.mode     = seq_mode;
        o.position = seq_position;
        o.pending  = PEND_W'(seq_backlog.size());
        return o;
    endfunction

    task automatic send_request(input sps_req_t r, input logic typed, input sps_rsp_t want);
        sps_rsp_t predicted;
        while ($urandom_range(99, 0) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = advance_sequencer(r);
        expected_results.push_back(typed ? want : predicted);
        if (r.command <= CMD_CAL)
            accepted_requests++;
    endtask

    task automatic send_item(input logic [CMD_W-1:0] code, input logic [ARG_W-1:0] arg,
                             input logic det);
        sps_req_t r;
        r.command  = code;
        r.argument = arg;
        r.detector = det;
        send_request(r, 1'b0, NO_RESULT);
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_item(CMD_TICK, ARG_W'($urandom), 1'($urandom_range(1, 0)));
    endtask

    task automatic send_random_command();
        logic [CMD_W-1:0] code;
        logic [ARG_W-1:0] arg;
        if (seq_backlog.size() >= QUEUE_DEPTH)
        begin
            code = CMD_W'($urandom_range(int'(CMD_CAL), int'(CMD_GOTO)));
            arg  = ARG_W'($urandom);
        end
        else
        begin
            case ($urandom_range(3, 0))
                0, 1:
                begin
                    code = CMD_GOTO;
                    arg  = ARG_W'($urandom_range(24, 0));
                end
                2:
                begin
                    code = CMD_W'($urandom_range(int'(CMD_SPEED), int'(CMD_WAIT)));
                    arg  = ARG_W'($urandom_range(2, 0));
                end
                default:
                begin
                    code = CMD_CAL;
                    arg  = ARG_W'($urandom);
                end
            endcase
        end
        send_item(code, arg, 1'($urandom_range(1, 0)));
    endtask

    task automatic run_random_phase(input int count);
        int start;
        int choice;
        start = accepted_requests;
        repeat (QUEUE_DEPTH + $urandom_range(4, 1))
            send_random_command();
        while (accepted_requests - start < count)
        begin
            choice = $urandom_range(99, 0);
            if (choice < 60)
            begin
                repeat ($urandom_range(3, 1))
                    send_random_command();
                send_ticks($urandom_range(60, 10));
            end
            else if (choice < 85)
            begin
                repeat ($urandom_range(4, 1))
                begin
                    if ($urandom_range(1, 0))
                        send_item(CMD_W'($urandom_range(LAST_CMD_CODE, FIRST_UNUSED_CMD)),
                                  ARG_W'($urandom), 1'($urandom_range(1, 0)));
                    else
                        send_ticks(1);
                end
            end
            else
            begin
                repeat ($urandom_range(6, 2))
                    send_random_command();
            end
        end
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        sps_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected", rsp, '0);
            else
            begin
                want = expected_results.pop_front();
                if (rsp.step_left !== want.step_left)
                    report_mismatch("step_left", rsp.step_left, want.step_left);
                if (rsp.step_right !== want.step_right)
                    report_mismatch("step_right", rsp.step_right, want.step_right);
                if (rsp.mode !== want.mode)
                    report_mismatch("mode", rsp.mode, want.mode);
                if (rsp.position !== want.position)
                    report_mismatch("position", rsp.position, want.position);
                if (rsp.pending !== want.pending)
                    report_mismatch("pending", rsp.pending, want.pending);
                if (rsp.dropped !== want.dropped)
                    report_mismatch("dropped", rsp.dropped, want.dropped);
            end
        end
        rsp_stall <= ($urandom_range(99, 0) < hold_pct);
    end

    initial
    begin
        int gap_by_phase  [PHASES];
        int hold_by_phase [PHASES];
        gap_by_phase  = '{0, 47, 0, 16};
        hold_by_phase = '{0, 0, 47, 16};
        plan = '{
            '{'{CMD_TICK, 16'hFFFF, 1'b1}, 1'b1, '{1'b0, 1'b1, MODE_CAL, 16'd0, 6'd0, 1'b0}},
            '{'{CMD_TICK, 16'h0000, 1'b1}, 1'b1, '{1'b0, 1'b1, MODE_CAL, 16'd0, 6'd0, 1'b0}},
            '{'{CMD_TICK, 16'h0000, 1'b0}, 1'b1, '{1'b0, 1'b0, MODE_IDLE, 16'd0, 6'd0, 1'b0}},
            '{'{CMD_TICK, 16'h5555, 1'b0}, 1'b1, '{1'b0, 1'b0, MODE_IDLE, 16'd0, 6'd0, 1'b0}},
            '{'{CMD_W'(FIRST_UNUSED_CMD), 16'hFFFF, 1'b1}, 1'b1,
              '{1'b0, 1'b0, MODE_IDLE, 16'd0, 6'd0, 1'b0}},
            '{'{CMD_W'(LAST_CMD_CODE), 16'h0000, 1'b0}, 1'b1,
              '{1'b0, 1'b0, MODE_IDLE, 16'd0, 6'd0, 1'b0}},
            '{'{CMD_GOTO, 16'd3, 1'b0}, 1'b1, '{1'b0, 1'b0, MODE_IDLE, 16'd0, 6'd1, 1'b0}},
            '{'{CMD_SPEED, 16'd0, 1'b1}, 1'b1, '{1'b0, 1'b0, MODE_IDLE, 16'd0, 6'd2, 1'b0}},
            '{'{CMD_GOTO, 16'd1, 1'b0}, 1'b1, '{1'b0, 1'b0, MODE_IDLE, 16'd0, 6'd3, 1'b0}},
            '{'{CMD_CAL, 16'hFFFF, 1'b0}, 1'b1, '{1'b0, 1'b0, MODE_IDLE, 16'd0, 6'd4, 1'b0}},
            '{'{CMD_WAIT, 16'd2, 1'b1}, 1'b1, '{1'b0, 1'b0, MODE_IDLE, 16'd0, 6'd5, 1'b0}},
            '{'{CMD_TICK, 16'hAAAA, 1'b0}, 1'b0, NO_RESULT},
            '{'{CMD_TICK, 16'h0001, 1'b1}, 1'b0, NO_RESULT},
            '{'{CMD_TICK, 16'h8000, 1'b0}, 1'b0, NO_RESULT},
            '{'{CMD_TICK, 16'h00FF, 1'b1}, 1'b0, NO_RESULT},
            '{'{CMD_TICK, 16'hFF00, 1'b0}, 1'b0, NO_RESULT},
            '{'{CMD_TICK, 16'h1234, 1'b1}, 1'b0, NO_RESULT},
            '{'{CMD_TICK, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
            '{'{CMD_TICK, 16'h0F0F, 1'b1}, 1'b0, NO_RESULT},
            '{'{CMD_TICK, 16'hF0F0, 1'b0}, 1'b0, NO_RESULT},
            '{'{CMD_TICK, 16'h0000, 1'b1}, 1'b0, NO_RESULT},
            '{'{CMD_TICK, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
            '{'{CMD_TICK, 16'h7FFF, 1'b1}, 1'b0, NO_RESULT},
            '{'{CMD_TICK, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
            '{'{CMD_TICK, 16'hFFFF, 1'b0}, 1'b0, NO_RESULT}
        };
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        foreach (plan[i])
            send_request(plan[i].stim, plan[i].typed, plan[i].want);
        for (int p = 0; p < PHASES; p++)
        begin
            send_gap_pct = gap_by_phase[p];
            hold_pct     = hold_by_phase[p];
            run_random_phase(RANDOM_PER_PHASE);
            wait_for_results();
        end
        repeat (8)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sps_pkg.sv
rtl/sps_ram.sv
rtl/stepper_position_sequencer_top.sv
verif/tb_stepper_position_sequencer_top.sv
